/* rtl/core/projected_box_screen_bounds_assert.svh */
// assertion macros for the box projection checker
`ifndef PROJECTED_BOX_SCREEN_BOUNDS_ASSERT_SVH
`define PROJECTED_BOX_SCREEN_BOUNDS_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define PBSB_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("pbsb assertion failed");

// next-cycle implication, disabled while dis is high
`define PBSB_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("pbsb assertion failed");

`endif

/* rtl/core/pbsb_pkg.sv */
// shared types and constants for the box projection block
package pbsb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NDC_LIM       = 24;
    localparam int COEF_W        = 32;
    localparam int EXT_W         = 20;
    localparam int SCR_W         = 13;
    localparam int CFG_AW        = 3;
    localparam int ROW_CNT       = 3;
    localparam int COEF_CNT      = 4;
    localparam int OUT_W         = 16;
    localparam int IN_DATA_W     = 232;
    localparam int OUT_DATA_W    = 64;
    localparam int Q_DEPTH       = 2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_BOX  = 1'b1;

    localparam logic [1:0] ROW_X    = 2'd0;
    localparam logic [1:0] ROW_Y    = 2'd1;
    localparam logic [1:0] ROW_W    = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam logic [CFG_AW-1:0] REG_MIN_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_MIN_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MIN_Z = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_X = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MAX_Y = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MAX_Z = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SCR_W = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SCR_H = 3'd7;

    localparam logic signed [EXT_W-1:0] RST_MIN_X = -20'sd39977;
    localparam logic signed [EXT_W-1:0] RST_MIN_Y = -20'sd16384;
    localparam logic signed [EXT_W-1:0] RST_MIN_Z = -20'sd85197;
    localparam logic signed [EXT_W-1:0] RST_MAX_X = 20'sd39977;
    localparam logic signed [EXT_W-1:0] RST_MAX_Y = 20'sd16384;
    localparam logic signed [EXT_W-1:0] RST_MAX_Z = 20'sd61604;
    localparam logic [SCR_W-1:0]        RST_SCR_W = 13'd1920;
    localparam logic [SCR_W-1:0]        RST_SCR_H = 13'd1080;

    typedef struct packed {
        logic                                kind;
        logic [1:0]                          row;
        logic [COEF_CNT-1:0][COEF_W-1:0]     word;
    } t_entry;

endpackage

/* rtl/core/pbsb_front.sv */
// input side: accepts items, drops dead loads, packs queue entries
module pbsb_front import pbsb_pkg::*; (
    input  logic                 i_s_tvalid,
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tuser,
    input  logic                 i_q_full,
    output logic                 o_s_tready,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [1:0]        row;
    logic              drop;

    assign row        = i_s_tdata[1:0];
    assign drop       = (i_s_tuser == KIND_LOAD) && (row == ROW_NONE);
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full && !drop;

    always_comb begin
        o_entry.kind = i_s_tuser;
        o_entry.row  = row;
        if (i_s_tuser == KIND_BOX) begin
            o_entry.word[0] = i_s_tdata[161:130];
            o_entry.word[1] = i_s_tdata[193:162];
            o_entry.word[2] = i_s_tdata[225:194];
            o_entry.word[3] = '0;
        end else begin
            o_entry.word[0] = i_s_tdata[33:2];
            o_entry.word[1] = i_s_tdata[65:34];
            o_entry.word[2] = i_s_tdata[97:66];
            o_entry.word[3] = i_s_tdata[129:98];
        end
    end

endmodule

/* rtl/core/pbsb_queue.sv */
// short item queue between front and back
module pbsb_queue import pbsb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_entry          r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_entry;
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/pbsb_back.sv */
// back end: row storage, corner projection, divide, bounds and output register
module pbsb_back import pbsb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [EXT_W-1:0]      i_cfg_data,
    input  logic                  i_q_valid,
    input  t_entry                i_q_entry,
    output logic                  o_q_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser
);

    localparam int SUM_W  = 65 - FRAC_BITS;
    localparam int MAG_W  = 64 - FRAC_BITS;
    localparam int Q_BITS = NDC_LIM + FRAC_BITS;
    localparam int Q_W    = Q_BITS + 1;
    localparam int NDC_W  = Q_W + 1;
    localparam int SC_W   = NDC_W + SCR_W + 1;
    localparam int SH     = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(Q_BITS + 1);
    localparam int P_W    = 2 * COEF_W;
    localparam logic signed [SUM_W+3:0] NEAR_LIM = (SUM_W + 4)'(1) << FRAC_BITS;
    localparam logic signed [SC_W-1:0]  ONE_F    = SC_W'(1) << FRAC_BITS;
    localparam logic [Q_W-1:0]          Q_SAT    = Q_W'(1) << Q_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_TEST, ST_DIV, ST_SCALE, ST_UPD, ST_FIN
    } t_state;

    t_state                     r_state;
    logic signed [EXT_W-1:0]    r_ext_min [3];
    logic signed [EXT_W-1:0]    r_ext_max [3];
    logic [SCR_W-1:0]           r_scr_w;
    logic [SCR_W-1:0]           r_scr_h;
    logic signed [COEF_W-1:0]   r_coef [ROW_CNT*COEF_CNT];
    logic signed [COEF_W-1:0]   r_lo [3];
    logic signed [COEF_W-1:0]   r_hi [3];
    logic signed [SUM_W-1:0]    r_acc [3];
    logic signed [P_W-1:0]      r_prod;
    logic [1:0]                 r_row;
    logic [1:0]                 r_j;
    logic [2:0]                 r_corner;
    logic                       r_first;
    logic                       r_vis;
    logic [MAG_W-1:0]           r_d;
    logic [MAG_W-1:0]           r_rem_x;
    logic [MAG_W-1:0]           r_rem_y;
    logic [Q_BITS-1:0]          r_n_x;
    logic [Q_BITS-1:0]          r_n_y;
    logic [Q_BITS-1:0]          r_q_x;
    logic [Q_BITS-1:0]          r_q_y;
    logic                       r_ovf_x;
    logic                       r_ovf_y;
    logic                       r_neg_x;
    logic                       r_neg_y;
    logic [CNT_W-1:0]           r_cnt;
    logic signed [SC_W-1:0]     r_mx;
    logic signed [SC_W-1:0]     r_my;
    logic signed [SC_W-1:0]     r_minx;
    logic signed [SC_W-1:0]     r_maxx;
    logic signed [SC_W-1:0]     r_miny;
    logic signed [SC_W-1:0]     r_maxy;
    logic                       r_out_valid;
    logic                       r_out_vis;
    logic [OUT_DATA_W-1:0]      r_out_data;

    logic signed [COEF_W-1:0]   coord;
    logic signed [COEF_W-1:0]   coef_sel;
    logic [3:0]                 coef_idx;
    logic signed [P_W-1:0]      prod;
    logic signed [P_W-1:0]      prod_sh;
    logic signed [SUM_W+3:0]    pw_ext;
    logic signed [SUM_W+3:0]    pw10;
    logic signed [SUM_W-1:0]    abs_x;
    logic signed [SUM_W-1:0]    abs_y;
    logic [MAG_W-1:0]           mag_x;
    logic [MAG_W-1:0]           mag_y;
    logic [MAG_W-1:0]           den;
    logic [MAG_W:0]             step_x;
    logic [MAG_W:0]             step_y;
    logic [Q_W-1:0]             qf_x;
    logic [Q_W-1:0]             qf_y;
    logic signed [NDC_W-1:0]    ndc_x;
    logic signed [NDC_W-1:0]    ndc_y;
    logic signed [SC_W-1:0]     hw;
    logic signed [SC_W-1:0]     hh;
    logic signed [SC_W-1:0]     sx;
    logic signed [SC_W-1:0]     sy;
    logic signed [SC_W-1:0]     left_f;
    logic signed [SC_W-1:0]     top_f;
    logic signed [SC_W-1:0]     wdt_f;
    logic signed [SC_W-1:0]     hgt_f;
    logic [OUT_W-1:0]           left_s;
    logic [OUT_W-1:0]           top_s;
    logic [OUT_W-1:0]           wdt_s;
    logic [OUT_W-1:0]           hgt_s;
    logic                       out_free;
    logic                       fin_fire;
    logic                       last_step;

    function automatic logic signed [COEF_W-1:0] sat_add(
        input logic signed [COEF_W-1:0] o,
        input logic signed [EXT_W-1:0]  e
    );
        logic signed [COEF_W:0] s;
        s = (COEF_W + 1)'(o) + (COEF_W + 1)'(e);
        if (s[COEF_W] != s[COEF_W-1]) begin
            sat_add = s[COEF_W] ? {1'b1, {(COEF_W - 1){1'b0}}} : {1'b0, {(COEF_W - 1){1'b1}}};
        end else begin
            sat_add = s[COEF_W-1:0];
        end
    endfunction

    // one restoring divide bit: {quotient bit, new remainder}
    function automatic logic [MAG_W:0] div_step(
        input logic [MAG_W-1:0] rem,
        input logic             nbit,
        input logic [MAG_W-1:0] d
    );
        logic [MAG_W:0] t;
        logic [MAG_W:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            div_step = {1'b1, diff[MAG_W-1:0]};
        end else begin
            div_step = {1'b0, t[MAG_W-1:0]};
        end
    endfunction

    function automatic logic [OUT_W-1:0] sat_s16(input logic signed [SC_W-1:0] v);
        if (v > SC_W'(32767)) begin
            sat_s16 = 16'h7fff;
        end else if (v < -SC_W'(32768)) begin
            sat_s16 = 16'h8000;
        end else begin
            sat_s16 = v[OUT_W-1:0];
        end
    endfunction

    function automatic logic [OUT_W-1:0] sat_u16(input logic signed [SC_W-1:0] v);
        if (v > SC_W'(65535)) begin
            sat_u16 = 16'hffff;
        end else begin
            sat_u16 = v[OUT_W-1:0];
        end
    endfunction

    always_comb begin
        case (r_j)
            2'd0:    coord = r_corner[0] ? r_hi[0] : r_lo[0];
            2'd1:    coord = r_corner[1] ? r_hi[1] : r_lo[1];
            default: coord = r_corner[2] ? r_hi[2] : r_lo[2];
        endcase
    end

    assign coef_idx = {r_row, 2'b00} + {2'b00, r_j};
    assign coef_sel = r_coef[coef_idx];
    assign prod     = P_W'(coef_sel) * P_W'(coord);
    assign prod_sh  = r_prod >>> FRAC_BITS;

    assign pw_ext = (SUM_W + 4)'(r_acc[2]);
    assign pw10   = (pw_ext <<< 3) + (pw_ext <<< 1);
    assign abs_x  = r_acc[0][SUM_W-1] ? -r_acc[0] : r_acc[0];
    assign abs_y  = r_acc[1][SUM_W-1] ? -r_acc[1] : r_acc[1];
    assign mag_x  = abs_x[MAG_W-1:0];
    assign mag_y  = abs_y[MAG_W-1:0];
    assign den    = r_acc[2][MAG_W-1:0];

    assign step_x = div_step(r_rem_x, r_n_x[Q_BITS-1], r_d);
    assign step_y = div_step(r_rem_y, r_n_y[Q_BITS-1], r_d);

    assign qf_x  = r_ovf_x ? Q_SAT : {1'b0, r_q_x};
    assign qf_y  = r_ovf_y ? Q_SAT : {1'b0, r_q_y};
    assign ndc_x = r_neg_x ? -$signed({1'b0, qf_x}) : $signed({1'b0, qf_x});
    assign ndc_y = r_neg_y ? -$signed({1'b0, qf_y}) : $signed({1'b0, qf_y});

    assign hw = $signed(SC_W'(r_scr_w >> 1) << SH);
    assign hh = $signed(SC_W'(r_scr_h >> 1) << SH);
    assign sx = hw + r_mx + ONE_F;
    assign sy = hh - r_my - ONE_F;

    // truncate toward zero on the doubled fixed point values
    assign left_f = r_minx[SC_W-1] ? -((-r_minx) >>> SH) : (r_minx >>> SH);
    assign top_f  = r_miny[SC_W-1] ? -((-r_miny) >>> SH) : (r_miny >>> SH);
    assign wdt_f  = (r_maxx - r_minx) >>> SH;
    assign hgt_f  = (r_maxy - r_miny) >>> SH;
    assign left_s = sat_s16(left_f);
    assign top_s  = sat_s16(top_f);
    assign wdt_s  = sat_u16(wdt_f);
    assign hgt_s  = sat_u16(hgt_f);

    assign out_free  = !r_out_valid || i_m_tready;
    assign fin_fire  = (r_state == ST_FIN) && out_free;
    assign last_step = (r_row == ROW_W) && (r_j == 2'd2);
    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_ext_min[0] <= RST_MIN_X;
            r_ext_min[1] <= RST_MIN_Y;
            r_ext_min[2] <= RST_MIN_Z;
            r_ext_max[0] <= RST_MAX_X;
            r_ext_max[1] <= RST_MAX_Y;
            r_ext_max[2] <= RST_MAX_Z;
            r_scr_w      <= RST_SCR_W;
            r_scr_h      <= RST_SCR_H;
            for (int i = 0; i < ROW_CNT * COEF_CNT; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_MIN_X: r_ext_min[0] <= i_cfg_data;
                    REG_MIN_Y: r_ext_min[1] <= i_cfg_data;
                    REG_MIN_Z: r_ext_min[2] <= i_cfg_data;
                    REG_MAX_X: r_ext_max[0] <= i_cfg_data;
                    REG_MAX_Y: r_ext_max[1] <= i_cfg_data;
                    REG_MAX_Z: r_ext_max[2] <= i_cfg_data;
                    REG_SCR_W: r_scr_w <= i_cfg_data[SCR_W-1:0];
                    REG_SCR_H: r_scr_h <= i_cfg_data[SCR_W-1:0];
                    default: ;
                endcase
            end

            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_entry.kind == KIND_LOAD) begin
                            for (int k = 0; k < COEF_CNT; k++) begin
                                r_coef[{i_q_entry.row, 2'(k)}] <= i_q_entry.word[k];
                            end
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                r_lo[k]  <= sat_add(i_q_entry.word[k], r_ext_min[k]);
                                r_hi[k]  <= sat_add(i_q_entry.word[k], r_ext_max[k]);
                                r_acc[k] <= SUM_W'(r_coef[k*COEF_CNT+3]);
                            end
                            r_corner <= '0;
                            r_row    <= ROW_X;
                            r_j      <= '0;
                            r_first  <= 1'b1;
                            r_vis    <= 1'b1;
                            r_state  <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod  <= prod;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc[r_row] <= r_acc[r_row] + prod_sh[SUM_W-1:0];
                    if (r_j == 2'd2) begin
                        r_j   <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                    r_state <= last_step ? ST_TEST : ST_MUL;
                end
                ST_TEST: begin
                    if (pw10 <= NEAR_LIM) begin
                        r_vis   <= 1'b0;
                        r_state <= ST_FIN;
                    end else begin
                        r_d     <= den;
                        r_rem_x <= mag_x >> NDC_LIM;
                        r_rem_y <= mag_y >> NDC_LIM;
                        r_ovf_x <= (mag_x >> NDC_LIM) >= den;
                        r_ovf_y <= (mag_y >> NDC_LIM) >= den;
                        r_n_x   <= {mag_x[NDC_LIM-1:0], FRAC_BITS'(0)};
                        r_n_y   <= {mag_y[NDC_LIM-1:0], FRAC_BITS'(0)};
                        r_neg_x <= r_acc[0][SUM_W-1];
                        r_neg_y <= r_acc[1][SUM_W-1];
                        r_cnt   <= CNT_W'(Q_BITS - 1);
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem_x <= step_x[MAG_W-1:0];
                    r_rem_y <= step_y[MAG_W-1:0];
                    r_q_x   <= {r_q_x[Q_BITS-2:0], step_x[MAG_W]};
                    r_q_y   <= {r_q_y[Q_BITS-2:0], step_y[MAG_W]};
                    r_n_x   <= r_n_x << 1;
                    r_n_y   <= r_n_y << 1;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_mx    <= SC_W'(ndc_x) * $signed(SC_W'(r_scr_w));
                    r_my    <= SC_W'(ndc_y) * $signed(SC_W'(r_scr_h));
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    if (r_first || sx < r_minx) r_minx <= sx;
                    if (r_first || sx > r_maxx) r_maxx <= sx;
                    if (r_first || sy < r_miny) r_miny <= sy;
                    if (r_first || sy > r_maxy) r_maxy <= sy;
                    r_first <= 1'b0;
                    if (r_corner == 3'd7) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_corner <= r_corner + 1'b1;
                        r_row    <= ROW_X;
                        r_j      <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_acc[k] <= SUM_W'(r_coef[k*COEF_CNT+3]);
                        end
                        r_state <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_vis   <= r_vis;
                        r_out_data  <= r_vis ? {hgt_s, wdt_s, top_s, left_s} : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/projected_box_screen_bounds.sv */
// top level of the box projection to screen bounds block
//
// channel   dir  handshake            tuser           tdata (lowest bit up)
// slave     in   i_s_tvalid/tready    kind            row_index, coef_a..d, origin_x..z
// master    out  o_m_tvalid/tready    visible         box_left, box_top, box_width, box_height
// config    in   i_cfg_we             -               i_cfg_addr selects, i_cfg_data value
//
// load item: written into the matrix rows as it leaves the queue, no result
// box item: worked one corner after another through the single shared 32x32
// multiplier and a one-bit-a-step divider run per corner
// a corner at or behind the near plane ends the item early with a zero result
// two-entry queue lets the input side keep taking items while the back end works
// synchronous active-low reset clears control, matrix rows and registers
module projected_box_screen_bounds import pbsb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // row_index, coef_a, coef_b, coef_c, coef_d,
                                               // origin_x, origin_y, origin_z, zero pad
    input  logic                  i_s_tuser,   // kind
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // box_left, box_top, box_width, box_height
    output logic                  o_m_tuser,   // visible
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [EXT_W-1:0]      i_cfg_data
);

    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    pbsb_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_s_tready (o_s_tready),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    pbsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    pbsb_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_entry  (head_entry),
        .o_q_pop    (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* rtl/core/pbsb_checker.sv */
// port-level checks for the box projection block, bound to the top level
`include "projected_box_screen_bounds_assert.svh"

module pbsb_checker import pbsb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser,
    input logic                  i_cfg_we,
    input logic [CFG_AW-1:0]     i_cfg_addr,
    input logic [EXT_W-1:0]      i_cfg_data
);

    // nothing comes out of reset
    `PBSB_ASSERT_NXT(a_rst_quiet, i_clk, 1'b0, !i_rst_n, !o_m_tvalid)

    // a rejected box carries an all-zero rectangle
    `PBSB_ASSERT_IMP(a_hidden_zero, i_clk, !i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)

    // a stalled result holds
    `PBSB_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind projected_box_screen_bounds pbsb_checker u_pbsb_checker (.*);
